### rtl/core/bolp_pkg.sv
// Shared types and constants for the ball offset line parser.
package bolp_pkg;

    // Characters recognized by the line parser
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Configuration register indexes
    localparam logic [7:0] REG_TIMEOUT_MS  = 8'd0;
    localparam logic [7:0] REG_OFFSET_MIN  = 8'd1;
    localparam logic [7:0] REG_OFFSET_MAX  = 8'd2;
    localparam logic [7:0] REG_SPIKE_LIMIT = 8'd3;

    // Configuration reset values
    localparam logic [15:0]        TIMEOUT_RESET     = 16'd100;
    localparam logic signed [15:0] OFFSET_MIN_RESET  = -16'sd1000;
    localparam logic signed [15:0] OFFSET_MAX_RESET  = 16'sd1000;
    localparam logic [14:0]        SPIKE_LIMIT_RESET = 15'd80;

    // Age saturates here
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    // Input word: a received character or a one millisecond tick
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [15:0] offset_mm;
        logic               ball_valid;
        logic [15:0]        frame_seq;
        logic [31:0]        line_count;
        logic [31:0]        parsed_count;
        logic               updated;
    } out_word_t;

    // Line parser phase
    typedef enum logic [2:0] {
        PH_LETTER,
        PH_COMMA1,
        PH_SIGN,
        PH_DIGITS,
        PH_FLAG,
        PH_END,
        PH_FAIL,
        PH_DONE
    } phase_t;

    // End-of-line event from the parser to the offset tracker
    typedef struct packed {
        logic               line_end;
        logic               line_ok;
        logic               flag;
        logic signed [15:0] pos;
    } line_evt_t;

endpackage

### rtl/core/bolp_parser.sv
// Character-level line parser with value accumulation and clamping.
module bolp_parser #(
    parameter int LINE_SIZE  = 24,
    parameter int MAX_DIGITS = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      is_char,
    input  logic [7:0]                data_byte,
    input  logic signed [15:0]        offset_min,
    input  logic signed [15:0]        offset_max,
    output bolp_pkg::line_evt_t       evt
);

    localparam int ACC_W  = $clog2(10 ** MAX_DIGITS);
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
    localparam int LEN_W  = $clog2(LINE_SIZE);
    localparam int CMP_W  = (ACC_W + 1 > 17) ? ACC_W + 1 : 17;

    bolp_pkg::phase_t    phase_reg, phase_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                neg_reg, neg_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                flag_reg, flag_next;

    logic                is_digit;
    logic [ACC_W-1:0]    digit_val;
    logic [ACC_W-1:0]    acc_times10;
    logic [CMP_W-1:0]    mag;
    logic signed [CMP_W-1:0] val_s;
    logic signed [CMP_W-1:0] min_ext;
    logic signed [CMP_W-1:0] max_ext;
    logic signed [15:0]  pos;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bolp_pkg::PH_LETTER;
            len_reg   <= '0;
            neg_reg   <= 1'b0;
            dcnt_reg  <= '0;
            acc_reg   <= '0;
            flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            neg_reg   <= neg_next;
            dcnt_reg  <= dcnt_next;
            acc_reg   <= acc_next;
            flag_reg  <= flag_next;
        end
    end

    // Digit decode and accumulate (x10 as two shifts)
    assign is_digit    = (data_byte >= bolp_pkg::CHAR_ZERO) &&
                         (data_byte <= bolp_pkg::CHAR_NINE);
    assign digit_val   = ACC_W'(data_byte[3:0]);
    assign acc_times10 = (acc_reg << 3) + (acc_reg << 1) + digit_val;

    // Signed value and clamp to bounds; lower bound wins when crossed
    assign mag     = CMP_W'(acc_reg);
    assign val_s   = neg_reg ? -$signed(mag) : $signed(mag);
    assign min_ext = {{(CMP_W-16){offset_min[15]}}, offset_min};
    assign max_ext = {{(CMP_W-16){offset_max[15]}}, offset_max};

    always_comb
    begin
        if (val_s < min_ext)
            pos = offset_min;
        else if (val_s > max_ext)
            pos = offset_max;
        else
            pos = val_s[15:0];
    end

    assign evt.line_end = is_char && (data_byte == bolp_pkg::CHAR_LF);
    assign evt.line_ok  = (phase_reg == bolp_pkg::PH_END) ||
                          (phase_reg == bolp_pkg::PH_DONE);
    assign evt.flag     = flag_reg;
    assign evt.pos      = pos;

    // Next state: line length, restart and per-character phase
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        neg_next   = neg_reg;
        dcnt_next  = dcnt_reg;
        acc_next   = acc_reg;
        flag_next  = flag_reg;

        if (!is_char || data_byte == bolp_pkg::CHAR_CR)
        begin
            // tick or CR: nothing changes
        end
        else if (data_byte == bolp_pkg::CHAR_LF ||
                 len_reg >= LEN_W'(LINE_SIZE - 1))
        begin
            // end of line or overflow: restart empty
            phase_next = bolp_pkg::PH_LETTER;
            len_next   = '0;
            neg_next   = 1'b0;
            dcnt_next  = '0;
            acc_next   = '0;
            flag_next  = 1'b0;
        end
        else
        begin
            len_next = len_reg + LEN_W'(1);
            if (phase_reg == bolp_pkg::PH_FAIL || phase_reg == bolp_pkg::PH_DONE)
            begin
                // text already ended or failed
            end
            else if (data_byte == bolp_pkg::CHAR_NUL)
            begin
                phase_next = (phase_reg == bolp_pkg::PH_END) ?
                             bolp_pkg::PH_DONE : bolp_pkg::PH_FAIL;
            end
            else
            begin
                unique case (phase_reg)
                    bolp_pkg::PH_LETTER:
                    begin
                        phase_next = (data_byte == bolp_pkg::CHAR_B) ?
                                     bolp_pkg::PH_COMMA1 : bolp_pkg::PH_FAIL;
                    end
                    bolp_pkg::PH_COMMA1:
                    begin
                        phase_next = (data_byte == bolp_pkg::CHAR_COMMA) ?
                                     bolp_pkg::PH_SIGN : bolp_pkg::PH_FAIL;
                    end
                    bolp_pkg::PH_SIGN:
                    begin
                        if (data_byte == bolp_pkg::CHAR_PLUS ||
                            data_byte == bolp_pkg::CHAR_MINUS)
                        begin
                            neg_next   = (data_byte == bolp_pkg::CHAR_MINUS);
                            phase_next = bolp_pkg::PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = digit_val;
                            dcnt_next  = DCNT_W'(1);
                            phase_next = bolp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = bolp_pkg::PH_FAIL;
                        end
                    end
                    bolp_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            if (dcnt_reg >= DCNT_W'(MAX_DIGITS))
                                phase_next = bolp_pkg::PH_FAIL;
                            else
                            begin
                                acc_next  = acc_times10;
                                dcnt_next = dcnt_reg + DCNT_W'(1);
                            end
                        end
                        else if (data_byte == bolp_pkg::CHAR_COMMA && dcnt_reg != '0)
                            phase_next = bolp_pkg::PH_FLAG;
                        else
                            phase_next = bolp_pkg::PH_FAIL;
                    end
                    bolp_pkg::PH_FLAG:
                    begin
                        if (data_byte == bolp_pkg::CHAR_ZERO ||
                            data_byte == bolp_pkg::CHAR_ONE)
                        begin
                            flag_next  = (data_byte == bolp_pkg::CHAR_ONE);
                            phase_next = bolp_pkg::PH_END;
                        end
                        else
                        begin
                            phase_next = bolp_pkg::PH_FAIL;
                        end
                    end
                    default:
                    begin
                        phase_next = bolp_pkg::PH_FAIL;
                    end
                endcase
            end
        end
    end

endmodule

### rtl/core/bolp_tracker.sv
// Offset tracker: spike filter, sequence, age and line counters.
module bolp_tracker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   tick,
    input  bolp_pkg::line_evt_t    evt,
    input  logic [15:0]            timeout_ms,
    input  logic [14:0]            spike_limit,
    output bolp_pkg::out_word_t    result
);

    logic signed [15:0] offset_reg, offset_next;
    logic               valid_reg, valid_next;
    logic [15:0]        seq_reg, seq_next;
    logic [15:0]        age_reg, age_next;
    logic [31:0]        lines_reg, lines_next;
    logic [31:0]        parsed_reg, parsed_next;
    logic               upd;

    logic signed [16:0] diff;
    logic [16:0]        abs_diff;
    logic               spike;
    logic [15:0]        age_inc;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            valid_reg  <= 1'b0;
            seq_reg    <= '0;
            age_reg    <= bolp_pkg::TIMEOUT_RESET;
            lines_reg  <= '0;
            parsed_reg <= '0;
        end
        else if (step)
        begin
            offset_reg <= offset_next;
            valid_reg  <= valid_next;
            seq_reg    <= seq_next;
            age_reg    <= age_next;
            lines_reg  <= lines_next;
            parsed_reg <= parsed_next;
        end
    end

    // Jump from the current offset
    assign diff     = {evt.pos[15], evt.pos} - {offset_reg[15], offset_reg};
    assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
    assign spike    = valid_reg && (abs_diff > {2'b00, spike_limit});

    // Saturating age
    assign age_inc = (age_reg != bolp_pkg::AGE_MAX) ? age_reg + 16'd1 : age_reg;

    // Next state
    always_comb
    begin
        offset_next = offset_reg;
        valid_next  = valid_reg;
        seq_next    = seq_reg;
        age_next    = age_reg;
        lines_next  = lines_reg;
        parsed_next = parsed_reg;
        upd         = 1'b0;

        if (tick)
        begin
            age_next = age_inc;
            if (age_inc >= timeout_ms)
                valid_next = 1'b0;
        end
        else if (evt.line_end)
        begin
            lines_next = lines_reg + 32'd1;
            if (evt.line_ok)
            begin
                parsed_next = parsed_reg + 32'd1;
                if (evt.flag && !spike)
                begin
                    offset_next = evt.pos;
                    seq_next    = seq_reg + 16'd1;
                    age_next    = '0;
                    valid_next  = 1'b1;
                    upd         = 1'b1;
                end
            end
        end
    end

    assign result.offset_mm    = offset_next;
    assign result.ball_valid   = valid_next;
    assign result.frame_seq    = seq_next;
    assign result.line_count   = lines_next;
    assign result.parsed_count = parsed_next;
    assign result.updated      = upd;

endmodule

### rtl/core/ball_offset_line_parser_unit.sv
// Top level of the ball offset line parser: word registers, config and core.
//
// Usage:
//   in_data carries one word per accepted handshake (in_valid high, in_stall
//   low): mode 0 is a received character, mode 1 a one millisecond tick.
//   Every input word yields exactly one result word on out_data (out_valid /
//   out_stall) with the current offset, validity, sequence number, line and
//   parsed-line counters, and an updated flag.
//   The input register feeds the parser and tracker logic, which loads the
//   result register.
//   Throughput is one word per cycle unless the receiver stalls; the state
//   loop of parser and tracker is combinational; back-to-back words are taken.
//   When the receiver stalls, the result register holds; one more word can
//   sit in the input register, after which in_stall rises until the result
//   is taken.
//   Reset clears both registers' valid flags and the parser state, loads the
//   config defaults (timeout 100, bounds -1000..1000, spike limit 80), sets
//   the age to 100 and the offset invalid. No clearing pass is needed.
//   Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and
//   are meant for idle periods; unknown indexes are ignored.
module ball_offset_line_parser_unit #(
    parameter int LINE_SIZE  = 24,
    parameter int MAX_DIGITS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bolp_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bolp_pkg::out_word_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    logic                  s1_valid_reg;
    bolp_pkg::in_word_t    s1_data_reg;
    logic                  out_valid_reg;
    bolp_pkg::out_word_t   out_data_reg;
    logic                  out_free;
    logic                  s1_adv;

    logic [15:0]           timeout_reg;
    logic signed [15:0]    min_reg;
    logic signed [15:0]    max_reg;
    logic [14:0]           spike_reg;

    bolp_pkg::line_evt_t   evt;
    bolp_pkg::out_word_t   res_next;

    // Handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Word registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_data_reg <= in_data;
        if (s1_adv)
            out_data_reg <= res_next;
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= bolp_pkg::TIMEOUT_RESET;
            min_reg     <= bolp_pkg::OFFSET_MIN_RESET;
            max_reg     <= bolp_pkg::OFFSET_MAX_RESET;
            spike_reg   <= bolp_pkg::SPIKE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bolp_pkg::REG_TIMEOUT_MS:  timeout_reg <= cfg_wdata;
                bolp_pkg::REG_OFFSET_MIN:  min_reg     <= cfg_wdata;
                bolp_pkg::REG_OFFSET_MAX:  max_reg     <= cfg_wdata;
                bolp_pkg::REG_SPIKE_LIMIT: spike_reg   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Line parser
    bolp_parser #(
        .LINE_SIZE  (LINE_SIZE),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_adv),
        .is_char    (!s1_data_reg.mode),
        .data_byte  (s1_data_reg.data_byte),
        .offset_min (min_reg),
        .offset_max (max_reg),
        .evt        (evt)
    );

    // Offset tracker
    bolp_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .tick        (s1_data_reg.mode),
        .evt         (evt),
        .timeout_ms  (timeout_reg),
        .spike_limit (spike_reg),
        .result      (res_next)
    );

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled while a register is empty");

    a_adv_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced word did not reach the result register");

    a_update_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.updated) |-> out_data_reg.ball_valid)
        else $error("offset update without ball_valid");

    a_update_bumps_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && res_next.updated && out_valid_reg) |=>
            (out_data_reg.frame_seq != $past(out_data_reg.frame_seq)))
        else $error("offset update without sequence change");

endmodule

### verif/ball_offset_line_parser_unit_tb.sv
// Self-checking testbench for the ball offset line parser unit.
`timescale 1ns / 100ps

module ball_offset_line_parser_unit_tb;

    localparam int LINE_SIZE   = 24;
    localparam int MAX_DIGITS  = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam logic [7:0] REG_UNUSED = 8'd4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    bolp_pkg::in_word_t     in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    bolp_pkg::out_word_t    out_data;
    logic                   cfg_wr_en = 1'b0;
    logic [7:0]             cfg_index = '0;
    logic [15:0]            cfg_wdata = '0;

    // Parser and tracker mirror
    bolp_pkg::phase_t   phase_q;
    logic [4:0]         len_q;
    logic               neg_q;
    logic [2:0]         ndig_q;
    logic [19:0]        acc_q;
    logic               flag_q;
    logic signed [15:0] offset_q;
    logic               ball_ok_q;
    logic [15:0]        seq_q;
    logic [15:0]        age_q;
    logic [31:0]        lines_q;
    logic [31:0]        parsed_q;

    // Configuration mirror
    logic [15:0]        tmo_q;
    logic signed [15:0] min_q;
    logic signed [15:0] max_q;
    logic [14:0]        spike_q;

    bolp_pkg::out_word_t expected_status[$];
    logic [7:0]  line_buf[$];
    int          words_sent = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          idle_en = 1'b1;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;

    ball_offset_line_parser_unit #(
        .LINE_SIZE  (LINE_SIZE),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic void restart_line();
        phase_q = bolp_pkg::PH_LETTER;
        neg_q   = 1'b0;
        ndig_q  = '0;
        acc_q   = '0;
        flag_q  = 1'b0;
    endfunction

    // Advance the mirror by one accepted word and queue the status it yields
    task automatic parse_and_track(input bolp_pkg::in_word_t w);
        bolp_pkg::out_word_t r;
        logic               upd;
        logic [7:0]         c;
        logic signed [15:0] pos;
        int                 v;
        int                 d;
        upd = 1'b0;
        c   = w.data_byte;
        if (w.mode)
        begin
            if (age_q < bolp_pkg::AGE_MAX)
                age_q = age_q + 16'd1;
            if (age_q >= tmo_q)
                ball_ok_q = 1'b0;
        end
        else if (c == bolp_pkg::CHAR_CR)
        begin
            // carriage return is skipped
        end
        else if (c == bolp_pkg::CHAR_LF)
        begin
            lines_q = lines_q + 32'd1;
            if (phase_q == bolp_pkg::PH_END || phase_q == bolp_pkg::PH_DONE)
            begin
                v = neg_q ? -int'(acc_q) : int'(acc_q);
                // lower bound wins when the bounds cross
                if (v < int'(min_q))
                    pos = min_q;
                else if (v > int'(max_q))
                    pos = max_q;
                else
                    pos = v[15:0];
                if (flag_q)
                begin
                    d = int'(pos) - int'(offset_q);
                    if (d < 0)
                        d = -d;
                    if (!(ball_ok_q && d > int'(spike_q)))
                    begin
                        seq_q     = seq_q + 16'd1;
                        offset_q  = pos;
                        age_q     = '0;
                        ball_ok_q = 1'b1;
                        upd       = 1'b1;
                    end
                end
                parsed_q = parsed_q + 32'd1;
            end
            len_q = '0;
            restart_line();
        end
        else if (int'(len_q) < LINE_SIZE - 1)
        begin
            len_q = len_q + 5'd1;
            if (phase_q != bolp_pkg::PH_FAIL && phase_q != bolp_pkg::PH_DONE)
            begin
                if (c == bolp_pkg::CHAR_NUL)
                    phase_q = (phase_q == bolp_pkg::PH_END) ?
                              bolp_pkg::PH_DONE : bolp_pkg::PH_FAIL;
                else
                begin
                    case (phase_q)
                        bolp_pkg::PH_LETTER:
                        begin
                            phase_q = (c == bolp_pkg::CHAR_B) ?
                                      bolp_pkg::PH_COMMA1 : bolp_pkg::PH_FAIL;
                        end
                        bolp_pkg::PH_COMMA1:
                        begin
                            phase_q = (c == bolp_pkg::CHAR_COMMA) ?
                                      bolp_pkg::PH_SIGN : bolp_pkg::PH_FAIL;
                        end
                        bolp_pkg::PH_SIGN:
                        begin
                            if (c == bolp_pkg::CHAR_PLUS || c == bolp_pkg::CHAR_MINUS)
                            begin
                                neg_q   = (c == bolp_pkg::CHAR_MINUS);
                                phase_q = bolp_pkg::PH_DIGITS;
                            end
                            else if (c >= bolp_pkg::CHAR_ZERO && c <= bolp_pkg::CHAR_NINE)
                            begin
                                acc_q   = 20'(c - bolp_pkg::CHAR_ZERO);
                                ndig_q  = 3'd1;
                                phase_q = bolp_pkg::PH_DIGITS;
                            end
                            else
                                phase_q = bolp_pkg::PH_FAIL;
                        end
                        bolp_pkg::PH_DIGITS:
                        begin
                            if (c >= bolp_pkg::CHAR_ZERO && c <= bolp_pkg::CHAR_NINE)
                            begin
                                if (int'(ndig_q) >= MAX_DIGITS)
                                    phase_q = bolp_pkg::PH_FAIL;
                                else
                                begin
                                    acc_q  = acc_q * 20'd10 +
                                             20'(c - bolp_pkg::CHAR_ZERO);
                                    ndig_q = ndig_q + 3'd1;
                                end
                            end
                            else if (c == bolp_pkg::CHAR_COMMA && ndig_q != 3'd0)
                                phase_q = bolp_pkg::PH_FLAG;
                            else
                                phase_q = bolp_pkg::PH_FAIL;
                        end
                        bolp_pkg::PH_FLAG:
                        begin
                            if (c == bolp_pkg::CHAR_ZERO || c == bolp_pkg::CHAR_ONE)
                            begin
                                flag_q  = (c == bolp_pkg::CHAR_ONE);
                                phase_q = bolp_pkg::PH_END;
                            end
                            else
                                phase_q = bolp_pkg::PH_FAIL;
                        end
                        default: phase_q = bolp_pkg::PH_FAIL;
                    endcase
                end
            end
        end
        else
        begin
            // line overflow: drop the character and start over
            len_q = '0;
            restart_line();
        end
        r.offset_mm    = offset_q;
        r.ball_valid   = ball_ok_q;
        r.frame_seq    = seq_q;
        r.line_count   = lines_q;
        r.parsed_count = parsed_q;
        r.updated      = upd;
        expected_status.push_back(r);
    endtask

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic m, input logic [7:0] b);
        bolp_pkg::in_word_t w;
        w.mode      = m;
        w.data_byte = b;
        while (idle_en && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_and_track(w);
        words_sent++;
    endtask

    task automatic flush_line(input bit sprinkle_cr);
        foreach (line_buf[i])
        begin
            if (sprinkle_cr && $urandom_range(0, 99) < 8)
                send_word(1'b0, bolp_pkg::CHAR_CR);
            send_word(1'b0, line_buf[i]);
        end
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == bolp_pkg::CHAR_LF || b == bolp_pkg::CHAR_CR);
        return b;
    endfunction

    // Body of a well-formed line without its LF; often lands near the offset
    task automatic build_good_line();
        int    span;
        int    target;
        int    cnt;
        string digits;
        line_buf.push_back(bolp_pkg::CHAR_B);
        line_buf.push_back(bolp_pkg::CHAR_COMMA);
        if (ball_ok_q && $urandom_range(0, 1) == 1)
        begin
            span   = (spike_q > 15'd1000) ? 1000 : int'(spike_q) + 40;
            target = int'(offset_q) + int'($urandom_range(0, 2 * span)) - span;
            if (target < 0)
            begin
                line_buf.push_back(bolp_pkg::CHAR_MINUS);
                target = -target;
            end
            else if ($urandom_range(0, 3) == 0)
                line_buf.push_back(bolp_pkg::CHAR_PLUS);
            digits = $sformatf("%0d", target);
            push_text(digits);
        end
        else
        begin
            case ($urandom_range(0, 2))
                1: line_buf.push_back(bolp_pkg::CHAR_PLUS);
                2: line_buf.push_back(bolp_pkg::CHAR_MINUS);
                default: ;
            endcase
            cnt = $urandom_range(1, MAX_DIGITS);
            repeat (cnt)
                line_buf.push_back(8'(bolp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        line_buf.push_back(bolp_pkg::CHAR_COMMA);
        line_buf.push_back(($urandom_range(0, 4) != 0) ?
                           bolp_pkg::CHAR_ONE : bolp_pkg::CHAR_ZERO);
    endtask

    // Drop valid and wait until every queued status word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            bolp_pkg::REG_TIMEOUT_MS:  tmo_q   = data;
            bolp_pkg::REG_OFFSET_MIN:  min_q   = data;
            bolp_pkg::REG_OFFSET_MAX:  max_q   = data;
            bolp_pkg::REG_SPIKE_LIMIT: spike_q = data[14:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] tmo, input logic [15:0] lo,
                                input logic [15:0] hi, input logic [15:0] spk);
        wait_drained();
        write_reg(bolp_pkg::REG_TIMEOUT_MS, tmo);
        write_reg(bolp_pkg::REG_OFFSET_MIN, lo);
        write_reg(bolp_pkg::REG_OFFSET_MAX, hi);
        write_reg(bolp_pkg::REG_SPIKE_LIMIT, spk);
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
    endtask

    // Mixed traffic: mostly well-formed lines, the rest broken or odd
    task automatic run_random_traffic(input int n);
        int goal;
        int kind;
        int cnt;
        int pos;
        goal = words_sent + n;
        while (words_sent < goal)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                cnt = $urandom_range(1, 3);
                repeat (cnt)
                    send_word(1'b1, 8'($urandom_range(0, 255)));
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                build_good_line();
                line_buf.push_back(bolp_pkg::CHAR_LF);
            end
            else if (kind < 63)
            begin
                // no digits, or more digits than allowed
                line_buf.push_back(bolp_pkg::CHAR_B);
                line_buf.push_back(bolp_pkg::CHAR_COMMA);
                if ($urandom_range(0, 1) == 1)
                    line_buf.push_back(($urandom_range(0, 1) == 1) ?
                                       bolp_pkg::CHAR_MINUS : bolp_pkg::CHAR_PLUS);
                cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(MAX_DIGITS + 1, 9);
                repeat (cnt)
                    line_buf.push_back(8'(bolp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
                line_buf.push_back(bolp_pkg::CHAR_COMMA);
                line_buf.push_back(bolp_pkg::CHAR_ONE);
                line_buf.push_back(bolp_pkg::CHAR_LF);
            end
            else if (kind < 71)
            begin
                // NUL somewhere in the line, junk after it
                build_good_line();
                pos = $urandom_range(0, line_buf.size());
                line_buf.insert(pos, bolp_pkg::CHAR_NUL);
                cnt = $urandom_range(0, 3);
                repeat (cnt)
                    line_buf.push_back(junk_byte());
                line_buf.push_back(bolp_pkg::CHAR_LF);
            end
            else if (kind < 79)
            begin
                // overrun the line buffer, then a good line
                cnt = $urandom_range(LINE_SIZE - 1, LINE_SIZE + 2);
                repeat (cnt)
                    line_buf.push_back(junk_byte());
                build_good_line();
                line_buf.push_back(bolp_pkg::CHAR_LF);
            end
            else if (kind < 90)
            begin
                // one corrupted character
                build_good_line();
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = junk_byte();
                line_buf.push_back(bolp_pkg::CHAR_LF);
            end
            else
            begin
                // tick burst, at times long enough to age past the timeout
                cnt = $urandom_range(1, (tmo_q < 16'd150) ? int'(tmo_q) + 2 : 150);
                repeat (cnt)
                    send_word(1'b1, 8'($urandom_range(0, 255)));
            end
            flush_line(1'b1);
        end
    endtask

    task automatic test_directed_lines();
        // plus sign, CR, first update from invalid
        push_text("B,+9,1");
        line_buf.push_back(bolp_pkg::CHAR_CR);
        line_buf.push_back(bolp_pkg::CHAR_LF);
        // below the lower bound, then rejected as a spike
        push_text("B,-9999,1");
        line_buf.push_back(bolp_pkg::CHAR_LF);
        // flag zero; NUL after complete text, trailing byte ignored
        push_text("B,1,0");
        line_buf.push_back(bolp_pkg::CHAR_NUL);
        line_buf.push_back(8'hFF);
        line_buf.push_back(bolp_pkg::CHAR_LF);
        flush_line(1'b0);
        // tick ignores its data byte
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_default_random();
        run_random_traffic(70);
    endtask

    task automatic test_wide_bounds_fast_timeout();
        apply_config(16'd1, 16'h8000, 16'h7FFF, 16'd0);
        run_random_traffic(50);
    endtask

    task automatic test_crossed_bounds();
        apply_config(16'd20, 16'sd500, -16'sd500, 16'hFFFF);
        run_random_traffic(50);
    endtask

    task automatic test_backpressure();
        apply_config(16'd300, -16'sd5, 16'sd5, 16'd3);
        idle_en     = 1'b0;
        hold_toggle = ~hold_toggle;
        repeat (4)
        begin
            build_good_line();
            line_buf.push_back(bolp_pkg::CHAR_LF);
        end
        flush_line(1'b0);
        idle_en = 1'b1;
        wait_drained();
        run_random_traffic(30);
    endtask

    // Offset turns invalid exactly when the age reaches the timeout
    task automatic test_timeout_edge();
        apply_config(16'd4, 16'h8000, 16'h7FFF, 16'h7FFF);
        idle_en = 1'b0;
        push_text("B,+32767,1");
        line_buf.push_back(bolp_pkg::CHAR_LF);
        flush_line(1'b0);
        repeat (6)
            send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_no_idle();
        apply_config(bolp_pkg::TIMEOUT_RESET, bolp_pkg::OFFSET_MIN_RESET,
                     bolp_pkg::OFFSET_MAX_RESET, 16'(bolp_pkg::SPIKE_LIMIT_RESET));
        idle_en = 1'b0;
        run_random_traffic(60);
        idle_en = 1'b1;
        run_random_traffic(20);
    endtask

    // Receiver stall: long hold-off on request, random idling otherwise
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_en && ($urandom_range(0, 99) < 25);
    end

    // Compare each accepted status word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        bolp_pkg::out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status word with no prediction waiting");
                fail_count++;
            end
            else
            begin
                e = expected_status.pop_front();
                if (out_data.offset_mm !== e.offset_mm)
                begin
                    $error("offset_mm: expected %0d, got %0d", e.offset_mm, out_data.offset_mm);
                    fail_count++;
                end
                if (out_data.ball_valid !== e.ball_valid)
                begin
                    $error("ball_valid: expected %0d, got %0d",
                           e.ball_valid, out_data.ball_valid);
                    fail_count++;
                end
                if (out_data.frame_seq !== e.frame_seq)
                begin
                    $error("frame_seq: expected %0d, got %0d", e.frame_seq, out_data.frame_seq);
                    fail_count++;
                end
                if (out_data.line_count !== e.line_count)
                begin
                    $error("line_count: expected %0d, got %0d",
                           e.line_count, out_data.line_count);
                    fail_count++;
                end
                if (out_data.parsed_count !== e.parsed_count)
                begin
                    $error("parsed_count: expected %0d, got %0d",
                           e.parsed_count, out_data.parsed_count);
                    fail_count++;
                end
                if (out_data.updated !== e.updated)
                begin
                    $error("updated: expected %0d, got %0d", e.updated, out_data.updated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ball_offset_line_parser_unit test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // mirror comes up as the block does after reset
        tmo_q     = bolp_pkg::TIMEOUT_RESET;
        min_q     = bolp_pkg::OFFSET_MIN_RESET;
        max_q     = bolp_pkg::OFFSET_MAX_RESET;
        spike_q   = bolp_pkg::SPIKE_LIMIT_RESET;
        len_q     = '0;
        restart_line();
        offset_q  = '0;
        ball_ok_q = 1'b0;
        seq_q     = '0;
        age_q     = bolp_pkg::TIMEOUT_RESET;
        lines_q   = '0;
        parsed_q  = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_default_random();
        test_wide_bounds_fast_timeout();
        test_crossed_bounds();
        test_backpressure();
        test_timeout_edge();
        test_random_no_idle();

        wait_drained();
        repeat (4)
            @(posedge clk);
        if (fail_count == 0)
            $display("ball_offset_line_parser_unit test passed");
        else
            $display("ball_offset_line_parser_unit test failed");
        $finish;
    end

endmodule
